// ----- hw/rtl/bdascii_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdascii_pkg
// Shared constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------

package bdascii_pkg;

  localparam int DEF_INPUT_WIDTH = 32;
  localparam int DEF_MAX_DIGITS  = 10;

  // double dabble shift steps done in one pipeline stage
  localparam int STEPS_PER_STAGE = 4;

  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;
  localparam logic [5:0] ASCII_ZERO  = 6'd48;

endpackage

// ----- hw/rtl/binary_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Writes an unsigned binary value out as decimal ASCII digits, most
// significant first, no leading zeros, last digit marked.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, value) takes one number per
//   transaction. Output channel (out_valid, out_stall, ascii_digit,
//   last_digit) gives one transaction per digit; last_digit is high on the
//   least significant digit. Zero gives the single digit '0'. A value with
//   more than MAX_DIGITS digits gives its MAX_DIGITS low digits.
//   A double dabble pipeline does four shift steps per stage, and a digit
//   register after its last stage feeds the output. The digit register
//   sends one digit per cycle while out_stall is low, so a value holds it
//   for as many output transactions as it has digits (1 to MAX_DIGITS).
//   The pipeline holds several values at once.
//   Reset clears all valid bits; nothing is emitted until new input.
//   When out_stall is high the current digit holds; while the last stage
//   waits on the digit register, the pipeline holds and in_stall is high.
// ----------------------------------------------------------------------------

module binary_to_decimal_ascii
  import bdascii_pkg::*;
#(
  parameter int INPUT_WIDTH = DEF_INPUT_WIDTH,
  parameter int MAX_DIGITS  = DEF_MAX_DIGITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [INPUT_WIDTH-1:0] value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [5:0]             ascii_digit,
  output logic                   last_digit
);

  localparam int NBCD    = (INPUT_WIDTH * 30103) / 100000 + 1;
  localparam int BW      = NBCD * 4;
  localparam int TW      = BW + INPUT_WIDTH;
  localparam int NSTAGES = (INPUT_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int SEL     = (NBCD < MAX_DIGITS) ? NBCD : MAX_DIGITS;
  localparam int IDX_W   = $clog2(SEL);

  logic [TW-1:0]      pipe_data [NSTAGES];
  logic [NSTAGES-1:0] pipe_valid;
  logic               advance;
  logic               ser_ready;

  logic [SEL*4-1:0]   digits;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   top;
  logic [BW-1:0]      bcd_result;
  logic [3:0]         cur_digit;

  assign ser_ready = !out_valid || (!out_stall && (idx == '0));
  assign advance   = !pipe_valid[NSTAGES-1] || ser_ready;
  assign in_stall  = !advance;

  for (genvar s = 0; s < NSTAGES; s++) begin : g_stage
    logic [TW-1:0] stage_in;
    logic [TW-1:0] stage_out;
    logic          valid_in;

    if (s == 0) begin : g_first
      assign stage_in = {{BW{1'b0}}, value};
      assign valid_in = in_valid;
    end else begin : g_rest
      assign stage_in = pipe_data[s-1];
      assign valid_in = pipe_valid[s-1];
    end

    always_comb begin
      stage_out = stage_in;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        if (s * STEPS_PER_STAGE + k < INPUT_WIDTH) begin
          for (int d = 0; d < NBCD; d++) begin
            if (stage_out[INPUT_WIDTH + 4*d +: 4] >= BCD_ADJ_MIN) begin
              stage_out[INPUT_WIDTH + 4*d +: 4] = stage_out[INPUT_WIDTH + 4*d +: 4] + BCD_ADJ;
            end
          end
          stage_out = stage_out << 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe_valid[s] <= 1'b0;
      end else if (advance) begin
        pipe_valid[s] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        pipe_data[s] <= stage_out;
      end
    end
  end

  assign bcd_result = pipe_data[NSTAGES-1][TW-1 -: BW];

  // position of the leading digit, capped at the digit limit
  always_comb begin
    top = '0;
    for (int d = 0; d < NBCD; d++) begin
      if (bcd_result[4*d +: 4] != 4'd0) begin
        top = (d < SEL) ? IDX_W'(d) : IDX_W'(SEL - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ser_ready) begin
      out_valid <= pipe_valid[NSTAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ser_ready) begin
      digits <= bcd_result[SEL*4-1:0];
      idx    <= top;
    end else if (!out_stall) begin
      idx <= idx - IDX_W'(1);
    end
  end

  assign cur_digit   = digits[4*idx +: 4];
  assign ascii_digit = ASCII_ZERO + {2'b00, cur_digit};
  assign last_digit  = (idx == '0);

endmodule
